/* design/lupc_pkg.sv */
// ----------------------------------------------------------------------------
// lupc_pkg
// Shared types and codes for the latch unlock pulse controller: input and
// result transaction layouts, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package lupc_pkg;

    // field widths
    localparam int unsigned MS_W     = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'd1;

    // configuration reset values
    localparam logic [MS_W-1:0] MAX_PULSE_RST    = 16'd5000;
    localparam logic [MS_W-1:0] MIN_INTERVAL_RST = 16'd2000;

    // saturation value of the millisecond counters
    localparam logic [MS_W-1:0] MS_MAX = '1;

    // item kinds
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_IDLE       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DRIVING    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STARTED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_SOON   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_LOCKED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_TIMED_OUT  = 3'd7;

    // input transaction
    typedef struct packed {
        logic            mode;
        logic            sense_low;
        logic [MS_W-1:0] request_timeout_ms;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic                drive_on;
        logic [STATUS_W-1:0] status;
        logic [MS_W-1:0]     duration_ms;
        logic                clamped;
    } out_item_t;

endpackage

/* design/latch_unlock_pulse_controller.sv */
// ----------------------------------------------------------------------------
// latch_unlock_pulse_controller
// Handles millisecond ticks and unlock requests, runs a bounded actuator
// pulse and reports one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction passes through an input register and then a result
// register before its result is offered.
// Throughput: one transaction per cycle; the result register frees the input
// side whenever the result is taken in the same cycle.
// Reset: rst_n clears the pulse state and counters and loads the register
// defaults (max pulse 5000, min interval 2000); both stages come up empty.
module latch_unlock_pulse_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lupc_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lupc_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [lupc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lupc_pkg::MS_W-1:0]           cfg_wdata
);
    import lupc_pkg::*;

    // configuration registers
    logic [MS_W-1:0] max_pulse_reg;
    logic [MS_W-1:0] min_interval_reg;

    // pulse state
    logic            active_reg,  active_next;
    logic [MS_W-1:0] elapsed_reg, elapsed_next;
    logic [MS_W-1:0] limit_reg,   limit_next;
    logic [MS_W-1:0] since_reg,   since_next;
    logic            ever_reg,    ever_next;

    // pipeline stages
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    logic            advance;
    logic            clamp;
    logic [MS_W-1:0] lim;
    logic [MS_W-1:0] elapsed_inc;

    // handshake: the input stage moves on when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pulse_reg    <= MAX_PULSE_RST;
            min_interval_reg <= MIN_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MAX_PULSE)
                max_pulse_reg <= cfg_wdata;
            else if (cfg_index == CFG_MIN_INTERVAL)
                min_interval_reg <= cfg_wdata;
        end
    end

    // clamp and saturating increment
    assign clamp       = in_item_reg.request_timeout_ms > max_pulse_reg;
    assign lim         = clamp ? max_pulse_reg : in_item_reg.request_timeout_ms;
    assign elapsed_inc = (elapsed_reg == MS_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    // per-transaction decision
    always_comb
    begin
        active_next   = active_reg;
        elapsed_next  = elapsed_reg;
        limit_next    = limit_reg;
        since_next    = since_reg;
        ever_next     = ever_reg;
        out_item_next = '{drive_on: 1'b0, status: ST_IDLE, duration_ms: '0, clamped: 1'b0};

        if (in_item_reg.mode == MODE_REQUEST)
        begin
            out_item_next.clamped = clamp;
            if (active_reg)
            begin
                out_item_next.drive_on = 1'b1;
                out_item_next.status   = ST_BUSY;
            end
            else if (ever_reg && (since_reg < min_interval_reg))
            begin
                out_item_next.status = ST_TOO_SOON;
            end
            else if (!in_item_reg.sense_low)
            begin
                out_item_next.status = ST_NOT_LOCKED;
            end
            else
            begin
                ever_next    = 1'b1;
                since_next   = '0;
                elapsed_next = '0;
                limit_next   = lim;
                // zero limit ends the pulse at once
                if (lim == '0)
                begin
                    active_next          = 1'b0;
                    out_item_next.status = ST_TIMED_OUT;
                end
                else
                begin
                    active_next            = 1'b1;
                    out_item_next.drive_on = 1'b1;
                    out_item_next.status   = ST_STARTED;
                end
            end
        end
        else
        begin
            if (since_reg != MS_MAX)
                since_next = since_reg + 1'b1;
            if (active_reg)
            begin
                elapsed_next = elapsed_inc;
                if (!in_item_reg.sense_low)
                begin
                    active_next               = 1'b0;
                    out_item_next.status      = ST_RELEASED;
                    out_item_next.duration_ms = elapsed_inc;
                end
                else if (elapsed_inc >= limit_reg)
                begin
                    active_next               = 1'b0;
                    out_item_next.status      = ST_TIMED_OUT;
                    out_item_next.duration_ms = elapsed_inc;
                end
                else
                begin
                    out_item_next.drive_on = 1'b1;
                    out_item_next.status   = ST_DRIVING;
                end
            end
        end
    end

    // control state and pulse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            elapsed_reg   <= '0;
            limit_reg     <= '0;
            since_reg     <= '0;
            ever_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                active_reg  <= active_next;
                elapsed_reg <= elapsed_next;
                limit_reg   <= limit_next;
                since_reg   <= since_next;
                ever_reg    <= ever_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= out_item_next;
    end

endmodule

/* design/lupc_checker.sv */
// ----------------------------------------------------------------------------
// lupc_port_checks
// Port-level checks for the latch unlock pulse controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module lupc_port_checks (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  lupc_pkg::out_item_t out_data
);
    import lupc_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // energized status codes drive the actuator
    a_drive_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_STARTED || out_data.status == ST_DRIVING ||
                      out_data.status == ST_BUSY) |-> out_data.drive_on)
        else $error("drive off with an active pulse status");

    // all other status codes leave it off
    a_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_IDLE || out_data.status == ST_TOO_SOON ||
                      out_data.status == ST_NOT_LOCKED || out_data.status == ST_RELEASED ||
                      out_data.status == ST_TIMED_OUT) |-> !out_data.drive_on)
        else $error("drive on without an active pulse status");

    // duration only reported when a pulse ends
    a_duration: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_RELEASED && out_data.status != ST_TIMED_OUT
        |-> out_data.duration_ms == '0)
        else $error("duration reported without pulse end");

    // tick-only status codes never carry a clamp flag
    a_clamp_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_IDLE || out_data.status == ST_DRIVING ||
                      out_data.status == ST_RELEASED) |-> !out_data.clamped)
        else $error("clamp flag on a tick result");

endmodule

bind latch_unlock_pulse_controller lupc_port_checks u_lupc_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* sim/lupc_checker.sv */
// ----------------------------------------------------------------------------
// lupc_checker
// Watches the input, result and register write ports of the latch unlock
// pulse controller. Keeps its own copy of the pulse state, works out the
// result of every accepted input transaction and compares each result
// transaction field by field, in order, against the oldest expectation.
// ----------------------------------------------------------------------------
module lupc_checker
    import lupc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MS_W-1:0]      cfg_wdata,
    output int unsigned          fail_count,
    output int unsigned          pending,
    output int unsigned          result_count
);

    localparam int unsigned REPORT_CAP = 20;

    // register copies
    logic [MS_W-1:0] lim_max_pulse;
    logic [MS_W-1:0] lim_min_gap;

    // pulse and interval state
    logic            drive_active;
    logic [MS_W-1:0] drive_elapsed;
    logic [MS_W-1:0] drive_limit;
    logic [MS_W-1:0] ticks_since_unlock;
    logic            has_unlocked;

    // results still owed by the block, oldest first
    out_item_t latch_results_q[$];

    // advance the pulse state by one transaction and return its result
    function automatic out_item_t next_latch_result(input in_item_t t);
        out_item_t       r;
        logic            over;
        logic [MS_W-1:0] lim;
        r = '0;
        if (t.mode == MODE_REQUEST) begin
            over      = t.request_timeout_ms > lim_max_pulse;
            lim       = over ? lim_max_pulse : t.request_timeout_ms;
            r.clamped = over;
            if (drive_active) begin
                r.drive_on = 1'b1;
                r.status   = ST_BUSY;
            end
            else if (has_unlocked && ticks_since_unlock < lim_min_gap) begin
                r.status = ST_TOO_SOON;
            end
            else if (!t.sense_low) begin
                r.status = ST_NOT_LOCKED;
            end
            else begin
                has_unlocked       = 1'b1;
                ticks_since_unlock = '0;
                drive_elapsed      = '0;
                drive_limit        = lim;
                // zero limit ends the pulse at once
                if (lim == '0) begin
                    drive_active = 1'b0;
                    r.status     = ST_TIMED_OUT;
                end
                else begin
                    drive_active = 1'b1;
                    r.drive_on   = 1'b1;
                    r.status     = ST_STARTED;
                end
            end
        end
        else begin
            if (ticks_since_unlock != MS_MAX)
                ticks_since_unlock = ticks_since_unlock + 1'b1;
            if (!drive_active) begin
                r.status = ST_IDLE;
            end
            else begin
                if (drive_elapsed != MS_MAX)
                    drive_elapsed = drive_elapsed + 1'b1;
                if (!t.sense_low) begin
                    drive_active  = 1'b0;
                    r.status      = ST_RELEASED;
                    r.duration_ms = drive_elapsed;
                end
                else if (drive_elapsed >= drive_limit) begin
                    drive_active  = 1'b0;
                    r.status      = ST_TIMED_OUT;
                    r.duration_ms = drive_elapsed;
                end
                else begin
                    r.drive_on = 1'b1;
                    r.status   = ST_DRIVING;
                end
            end
        end
        return r;
    endfunction

    // count and report one field mismatch
    task automatic note_field(input string label, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t checker: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // track writes, predict on input transactions, compare on results
    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            lim_max_pulse      = MAX_PULSE_RST;
            lim_min_gap        = MIN_INTERVAL_RST;
            drive_active       = 1'b0;
            drive_elapsed      = '0;
            drive_limit        = '0;
            ticks_since_unlock = '0;
            has_unlocked       = 1'b0;
            latch_results_q.delete();
            fail_count         = 0;
            result_count       = 0;
            pending           <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAX_PULSE:    lim_max_pulse = cfg_wdata;
                    CFG_MIN_INTERVAL: lim_min_gap   = cfg_wdata;
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                latch_results_q.push_back(next_latch_result(in_data));
            if (out_valid && out_ready) begin
                result_count++;
                if (latch_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t checker: result with none expected, got %h",
                                 $time, out_data);
                end
                else begin
                    want = latch_results_q.pop_front();
                    note_field("drive_on", 32'(want.drive_on), 32'(out_data.drive_on));
                    note_field("status", 32'(want.status), 32'(out_data.status));
                    note_field("duration_ms", 32'(want.duration_ms),
                               32'(out_data.duration_ms));
                    note_field("clamped", 32'(want.clamped), 32'(out_data.clamped));
                end
            end
            pending <= latch_results_q.size();
        end
    end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the latch unlock pulse controller with directed corner cases and
// random tick and request mixes over several register settings, with random
// gaps on both handshakes. Checking is done by lupc_checker.
// ----------------------------------------------------------------------------
module testbench;

    import lupc_pkg::*;

    localparam int unsigned LATENCY_PAUSE = 6;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_PER_SETTING = 128;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MS_W-1:0]      cfg_wdata = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned result_count;

    int unsigned send_gap_pct   = 11;
    int unsigned recv_stall_pct = 60;
    int unsigned sent_count     = 0;
    int unsigned write_count    = 0;
    int unsigned cycle_count    = 0;
    logic [MS_W-1:0] cur_max_pulse = MAX_PULSE_RST;

    latch_unlock_pulse_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lupc_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one input transaction and wait until it is taken
    task automatic send_item(input logic mode, input logic sense,
                             input logic [MS_W-1:0] req_ms);
        in_item_t t;
        t.mode               = mode;
        t.sense_low          = sense;
        t.request_timeout_ms = req_ms;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    // stop sending and wait until every result is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        write_count++;
    endtask

    // new register setting, only with the block drained
    task automatic apply_setting(input logic [MS_W-1:0] max_ms, input logic [MS_W-1:0] gap_ms);
        drain_results();
        write_reg(CFG_MAX_PULSE, max_ms);
        write_reg(CFG_MIN_INTERVAL, gap_ms);
        cur_max_pulse = max_ms;
    endtask

    // mostly short requests near the clamp, some full-range values
    function automatic in_item_t random_item();
        in_item_t    t;
        int unsigned pick;
        int unsigned small_top;
        t.mode      = ($urandom_range(99) < 22) ? MODE_REQUEST : MODE_TICK;
        t.sense_low = ($urandom_range(99) < 88);
        small_top   = (cur_max_pulse < 12) ? int'(cur_max_pulse) + 3 : 12;
        pick        = $urandom_range(99);
        if (pick < 70)
            t.request_timeout_ms = MS_W'($urandom_range(small_top, 0));
        else if (pick < 80)
            t.request_timeout_ms = '0;
        else if (pick < 90)
            t.request_timeout_ms = MS_W'($urandom_range(65535, 0));
        else
            t.request_timeout_ms = $urandom_range(1) ? cur_max_pulse : cur_max_pulse + 1'b1;
        return t;
    endfunction

    initial
    begin
        in_item_t        t;
        int unsigned     ph;
        int unsigned     s;
        int unsigned     n;
        logic [MS_W-1:0] max_ms;
        logic [MS_W-1:0] gap_ms;

        // reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, register defaults
        send_item(MODE_TICK, 1'b0, '0);
        send_item(MODE_REQUEST, 1'b0, 16'd10);
        send_item(MODE_REQUEST, 1'b1, MS_MAX);
        send_item(MODE_REQUEST, 1'b1, 16'd5);
        send_item(MODE_REQUEST, 1'b0, MS_MAX);
        send_item(MODE_TICK, 1'b1, '0);
        send_item(MODE_TICK, 1'b0, '0);
        send_item(MODE_REQUEST, 1'b1, 16'd3);

        // zero limit: pulse ends on the request itself
        apply_setting('0, '0);
        send_item(MODE_REQUEST, 1'b1, 16'd7);
        send_item(MODE_REQUEST, 1'b1, '0);

        // timeout, release, too soon and not locked on a short pulse
        apply_setting(16'd3, 16'd2);
        send_item(MODE_REQUEST, 1'b1, 16'd3);
        repeat (3) send_item(MODE_TICK, 1'b1, '0);
        send_item(MODE_REQUEST, 1'b1, 16'd4);
        send_item(MODE_TICK, 1'b0, '0);
        send_item(MODE_REQUEST, 1'b1, 16'd1);
        send_item(MODE_TICK, 1'b1, '0);
        send_item(MODE_REQUEST, 1'b0, 16'd1);
        send_item(MODE_REQUEST, 1'b1, 16'd1);
        send_item(MODE_TICK, 1'b1, '0);

        // random mixes, three settings per handshake gap phase
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:       begin send_gap_pct = 11; recv_stall_pct = 60; end
                1:       begin send_gap_pct = 60; recv_stall_pct = 11; end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (s = 0; s < 3; s++)
            begin
                case (ph * 3 + s)
                    0:       begin max_ms = 16'd4;  gap_ms = 16'd3;  end
                    1:       begin max_ms = '0;     gap_ms = '0;     end
                    2:       begin max_ms = MS_MAX; gap_ms = 16'd2;  end
                    3:       begin max_ms = 16'd7;  gap_ms = MS_MAX; end
                    default:
                    begin
                        max_ms = MS_W'($urandom_range(10, 1));
                        gap_ms = MS_W'($urandom_range(6, 0));
                    end
                endcase
                apply_setting(max_ms, gap_ms);
                for (n = 0; n < RANDOM_PER_SETTING; n++)
                begin
                    t = random_item();
                    send_item(t.mode, t.sense_low, t.request_timeout_ms);
                end
            end
        end

        drain_results();

        $display("summary: %0d transactions sent, %0d results checked, %0d register writes",
                 sent_count, result_count, write_count);
        $display("summary: directed corners and random mixes under nine settings");
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
